[rtl/core/ecs_pkg.sv]
// ----------------------------------------------------------------------------
// ecs_pkg
// Shared types and constants for the elevator call scheduler.
// ----------------------------------------------------------------------------
package ecs_pkg;

  localparam int FLOORS_DEF  = 4;
  localparam int CMD_W       = 2;
  localparam int FLOOR_W     = 2;
  localparam int NEXT_W      = 2;
  localparam int CAB_LAMP_W  = 4;
  localparam int UP_LAMP_W   = 3;
  localparam int DOWN_LAMP_W = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD       = 2'd0,
    CMD_CLEAR     = 2'd1,
    CMD_CLEAR_ALL = 2'd2,
    CMD_QUERY     = 2'd3
  } cmd_t;

  // which calls a cell matches during a scan pass
  typedef enum logic [1:0] {
    COND_UP_CAB   = 2'd0,
    COND_DOWN_CAB = 2'd1,
    COND_UP       = 2'd2,
    COND_DOWN     = 2'd3
  } cond_t;

  typedef enum logic [1:0] {
    PASS_ONE   = 2'd0,
    PASS_TWO   = 2'd1,
    PASS_THREE = 2'd2
  } pass_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    logic  apply;
    cmd_t  cmd;
    logic  going_up;
    logic  cab_call;
    logic  load;
    logic  shift;
    logic  shift_up;
    cond_t cond;
  } cell_ctrl_t;

endpackage

[rtl/core/ecs_floor_cell.sv]
// ----------------------------------------------------------------------------
// ecs_floor_cell
// One floor: cab, hall-up and hall-down call bits plus one stage of the scan
// token chain.
// ----------------------------------------------------------------------------
module ecs_floor_cell
  import ecs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       sel,
  input  logic       load_bit,
  input  logic       tok_below,
  input  logic       tok_above,
  input  logic       is_top,
  input  logic       is_bottom,
  output logic       token,
  output logic       hit,
  output logic       cab_lamp,
  output logic       up_lamp,
  output logic       down_lamp
);

  logic cab;
  logic upc;
  logic dnc;
  logic cab_next;
  logic upc_next;
  logic dnc_next;
  logic token_next;
  logic match;

  always_comb begin
    cab_next = cab;
    upc_next = upc;
    dnc_next = dnc;
    if (ctrl.apply) begin
      unique case (ctrl.cmd)
        CMD_ADD: begin
          if (sel) begin
            if (ctrl.cab_call) cab_next = 1'b1;
            else if (ctrl.going_up) upc_next = 1'b1;
            else dnc_next = 1'b1;
          end
        end
        CMD_CLEAR: begin
          if (sel) begin
            cab_next = 1'b0;
            if (ctrl.going_up) upc_next = 1'b0;
            else dnc_next = 1'b0;
            if (is_top) dnc_next = 1'b0;
            if (is_bottom) upc_next = 1'b0;
          end
        end
        CMD_CLEAR_ALL: begin
          cab_next = 1'b0;
          upc_next = 1'b0;
          dnc_next = 1'b0;
        end
        CMD_QUERY: begin
        end
      endcase
    end
  end

  always_comb begin
    if (ctrl.load) token_next = load_bit;
    else if (ctrl.shift) token_next = ctrl.shift_up ? tok_below : tok_above;
    else token_next = token;
  end

  always_comb begin
    unique case (ctrl.cond)
      COND_UP_CAB:   match = upc | cab;
      COND_DOWN_CAB: match = dnc | cab;
      COND_UP:       match = upc;
      COND_DOWN:     match = dnc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cab   <= 1'b0;
      upc   <= 1'b0;
      dnc   <= 1'b0;
      token <= 1'b0;
    end else begin
      cab   <= cab_next;
      upc   <= upc_next;
      dnc   <= dnc_next;
      token <= token_next;
    end
  end

  assign hit       = token & match;
  assign cab_lamp  = cab;
  assign up_lamp   = upc & ~is_top;
  assign down_lamp = dnc & ~is_bottom;

endmodule

[rtl/core/ecs_scan_ctrl.sv]
// ----------------------------------------------------------------------------
// ecs_scan_ctrl
// Transaction control and three-pass scan sequencer driving the cell chain.
// ----------------------------------------------------------------------------
module ecs_scan_ctrl
  import ecs_pkg::*;
#(
  parameter int FLOORS = FLOORS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [CMD_W-1:0]             command,
  input  logic [FLOOR_W-1:0]           floor,
  input  logic                         going_up,
  input  logic                         cab_call,
  input  logic [FLOORS-1:0]            hit_vec,
  output logic                         busy,
  output cell_ctrl_t                   ctrl,
  output logic [FLOORS-1:0]            sel_vec,
  output logic [FLOORS-1:0]            load_vec,
  output logic                         done,
  output logic                         found,
  output logic [$clog2(FLOORS)-1:0]    pick
);

  localparam int PW = $clog2(FLOORS);
  localparam int CW = (PW > FLOOR_W) ? PW : FLOOR_W;
  localparam logic [PW-1:0] TOP = PW'(FLOORS - 1);

  state_t        state;
  state_t        state_next;
  pass_t         pass;
  pass_t         pass_next;
  logic [PW-1:0] pos;
  logic [PW-1:0] pos_next;
  logic [PW-1:0] f_cur;
  logic          dir_up;

  logic [CW-1:0] fl_w;
  logic          fl_ok;
  logic [PW-1:0] f_in;
  logic          accept;
  logic          any_hit;
  logic          p3_empty;
  logic          at_end;
  logic          finish;
  logic          move_up;
  logic [PW-1:0] end_pos;
  logic [PW-1:0] start_next;
  logic [PW-1:0] load_pos;
  cond_t         cond;

  assign fl_w    = CW'(floor);
  assign fl_ok   = fl_w <= CW'(FLOORS - 1);
  assign f_in    = fl_ok ? PW'(fl_w) : TOP;
  assign accept  = start & ~busy;
  assign busy    = (state != S_IDLE);
  assign any_hit = |hit_vec;

  always_comb begin
    for (int i = 0; i < FLOORS; i++) begin
      sel_vec[i]  = fl_ok && (fl_w == CW'(i));
      load_vec[i] = (load_pos == PW'(i));
    end
  end

  // pass set-up
  always_comb begin
    move_up    = 1'b1;
    end_pos    = TOP;
    cond       = COND_UP_CAB;
    start_next = '0;
    case (pass)
      PASS_ONE: begin
        move_up    = dir_up;
        end_pos    = dir_up ? TOP : '0;
        cond       = dir_up ? COND_UP_CAB : COND_DOWN_CAB;
        start_next = dir_up ? TOP : '0;
      end
      PASS_TWO: begin
        move_up    = ~dir_up;
        end_pos    = dir_up ? '0 : TOP;
        cond       = dir_up ? COND_DOWN_CAB : COND_UP_CAB;
        start_next = dir_up ? '0 : TOP;
      end
      PASS_THREE: begin
        move_up    = dir_up;
        end_pos    = f_cur;
        cond       = dir_up ? COND_UP : COND_DOWN;
        start_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign p3_empty = dir_up && (pass == PASS_THREE) && (pos == f_cur);
  assign at_end   = (pos == end_pos);

  // next state
  always_comb begin
    state_next = state;
    pass_next  = pass;
    pos_next   = pos;
    finish     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_SCAN;
          pass_next  = PASS_ONE;
          pos_next   = f_in;
        end
      end
      S_SCAN: begin
        if (p3_empty || any_hit || (at_end && pass == PASS_THREE)) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end else if (at_end) begin
          pass_next = (pass == PASS_ONE) ? PASS_TWO : PASS_THREE;
          pos_next  = start_next;
        end else begin
          pos_next = move_up ? pos + PW'(1) : pos - PW'(1);
        end
      end
    endcase
  end

  // outputs to the cells
  always_comb begin
    ctrl.apply    = 1'b0;
    ctrl.cmd      = cmd_t'(command);
    ctrl.going_up = going_up;
    ctrl.cab_call = cab_call;
    ctrl.load     = 1'b0;
    ctrl.shift    = 1'b0;
    ctrl.shift_up = move_up;
    ctrl.cond     = cond;
    load_pos      = start_next;
    unique case (state)
      S_IDLE: begin
        ctrl.apply = start;
        ctrl.load  = start;
        load_pos   = f_in;
      end
      S_SCAN: begin
        if (!p3_empty && !any_hit) begin
          ctrl.load  = at_end && (pass != PASS_THREE);
          ctrl.shift = !at_end;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pass  <= PASS_ONE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
      done  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    pos <= pos_next;
    if (accept) begin
      f_cur  <= f_in;
      dir_up <= going_up;
    end
    if (finish) begin
      found <= any_hit && !p3_empty;
      pick  <= (any_hit && !p3_empty) ? pos : '0;
    end
  end

`ifndef SYNTH
  a_done_idle : assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_done_single : assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_none_zero : assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (pick == '0))
    else $error("no call pending but floor not zero");
  a_hit_single : assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> $onehot0(hit_vec))
    else $error("more than one cell reports a hit");
`endif

endmodule

[rtl/core/elevator_call_scheduler.sv]
// ----------------------------------------------------------------------------
// elevator_call_scheduler
// The command is applied at the accepting edge, then the token walks the
// cell chain one floor per cycle during the scan; the result strobe follows
// in the next cycle. busy falls with the strobe, so the next transaction can
// be accepted from then on. The receiver cannot
// stall. Synchronous reset clears all call masks and returns to idle.
// ----------------------------------------------------------------------------
module elevator_call_scheduler
  import ecs_pkg::*;
#(
  parameter int FLOORS = FLOORS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [CMD_W-1:0]       command,
  input  logic [FLOOR_W-1:0]     floor,
  input  logic                   going_up,
  input  logic                   cab_call,
  output logic                   done,
  output logic [NEXT_W-1:0]      next_floor,
  output logic                   has_next,
  output logic                   cab_pending,
  output logic [CAB_LAMP_W-1:0]  cab_lamps,
  output logic [UP_LAMP_W-1:0]   up_lamps,
  output logic [DOWN_LAMP_W-1:0] down_lamps
);

  localparam int PW = $clog2(FLOORS);

  cell_ctrl_t        ctrl;
  logic [FLOORS-1:0] sel_vec;
  logic [FLOORS-1:0] load_vec;
  logic [FLOORS-1:0] hit_vec;
  logic [FLOORS-1:0] token_vec;
  logic [FLOORS-1:0] cab_vec;
  logic [FLOORS-1:0] up_vec;
  logic [FLOORS-1:0] dn_vec;
  logic              found;
  logic [PW-1:0]     pick;

  ecs_scan_ctrl #(.FLOORS(FLOORS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .command  (command),
    .floor    (floor),
    .going_up (going_up),
    .cab_call (cab_call),
    .hit_vec  (hit_vec),
    .busy     (busy),
    .ctrl     (ctrl),
    .sel_vec  (sel_vec),
    .load_vec (load_vec),
    .done     (done),
    .found    (found),
    .pick     (pick)
  );

  for (genvar i = 0; i < FLOORS; i++) begin : g_cell
    logic below;
    logic above;
    if (i == 0) begin : g_bot
      assign below = 1'b0;
    end else begin : g_mid_b
      assign below = token_vec[i-1];
    end
    if (i == FLOORS - 1) begin : g_top
      assign above = 1'b0;
    end else begin : g_mid_a
      assign above = token_vec[i+1];
    end

    ecs_floor_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .sel       (sel_vec[i]),
      .load_bit  (load_vec[i]),
      .tok_below (below),
      .tok_above (above),
      .is_top    ((i == FLOORS - 1) ? 1'b1 : 1'b0),
      .is_bottom ((i == 0) ? 1'b1 : 1'b0),
      .token     (token_vec[i]),
      .hit       (hit_vec[i]),
      .cab_lamp  (cab_vec[i]),
      .up_lamp   (up_vec[i]),
      .down_lamp (dn_vec[i])
    );
  end

  assign next_floor  = NEXT_W'(pick);
  assign has_next    = found;
  assign cab_pending = |cab_vec;
  assign cab_lamps   = CAB_LAMP_W'(cab_vec);
  assign up_lamps    = UP_LAMP_W'(up_vec);
  assign down_lamps  = DOWN_LAMP_W'(dn_vec);

endmodule

[dv/elevator_call_checker.sv]
// ----------------------------------------------------------------------------
// elevator_call_checker
// Watches the command and result channels of the elevator call scheduler.
// Keeps its own cab, hall-up and hall-down call masks and works out the
// status that each accepted transaction must return. This covers the
// three-pass directional scan, the end-floor clears and the lamp masking.
// Results are checked in order against the oldest expected status.
// ----------------------------------------------------------------------------
module elevator_call_checker
  import ecs_pkg::*;
#(
  parameter int FLOORS = FLOORS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   busy,
  input  logic [CMD_W-1:0]       command,
  input  logic [FLOOR_W-1:0]     floor,
  input  logic                   going_up,
  input  logic                   cab_call,
  input  logic                   done,
  input  logic [NEXT_W-1:0]      next_floor,
  input  logic                   has_next,
  input  logic                   cab_pending,
  input  logic [CAB_LAMP_W-1:0]  cab_lamps,
  input  logic [UP_LAMP_W-1:0]   up_lamps,
  input  logic [DOWN_LAMP_W-1:0] down_lamps,
  output int                     mismatch_count,
  output logic                   all_checked
);

  typedef struct packed {
    logic [NEXT_W-1:0]      next_floor;
    logic                   has_next;
    logic                   cab_pending;
    logic [CAB_LAMP_W-1:0]  cab_lamps;
    logic [UP_LAMP_W-1:0]   up_lamps;
    logic [DOWN_LAMP_W-1:0] down_lamps;
  } call_status_t;

  localparam int NO_TARGET = -1;

  logic [FLOORS-1:0] cab_mask;
  logic [FLOORS-1:0] up_mask;
  logic [FLOORS-1:0] down_mask;
  call_status_t      status_q[$];
  int                fails = 0;

  // three-pass scan from the car floor in the travel direction
  function automatic int scan_target(int car, logic up);
    if (up) begin
      for (int i = car; i < FLOORS; i++)
        if (up_mask[i] || cab_mask[i]) return i;
      for (int i = FLOORS - 1; i >= 0; i--)
        if (down_mask[i] || cab_mask[i]) return i;
      for (int i = 0; i < car; i++)
        if (up_mask[i]) return i;
    end else begin
      for (int i = car; i >= 0; i--)
        if (down_mask[i] || cab_mask[i]) return i;
      for (int i = 0; i < FLOORS; i++)
        if (up_mask[i] || cab_mask[i]) return i;
      for (int i = FLOORS - 1; i >= car; i--)
        if (down_mask[i]) return i;
    end
    return NO_TARGET;
  endfunction

  function automatic call_status_t serve_call(cmd_t cmd, logic [FLOOR_W-1:0] fl,
                                              logic up, logic cab);
    logic [FLOORS-1:0] sel;
    logic [31:0]       up_wide;
    logic [31:0]       down_wide;
    int                car;
    int                tgt;
    call_status_t      st;
    sel = '0;
    car = FLOORS - 1;
    if (int'(fl) < FLOORS) begin
      sel[fl] = 1'b1;
      car = int'(fl);
    end
    case (cmd)
      CMD_ADD: begin
        if (cab) cab_mask = cab_mask | sel;
        else if (up) up_mask = up_mask | sel;
        else down_mask = down_mask | sel;
      end
      CMD_CLEAR: begin
        cab_mask = cab_mask & ~sel;
        if (up) up_mask = up_mask & ~sel;
        else down_mask = down_mask & ~sel;
        // end floors drop both hall directions
        if (sel[FLOORS-1]) down_mask = down_mask & ~sel;
        if (sel[0]) up_mask = up_mask & ~sel;
      end
      CMD_CLEAR_ALL: begin
        cab_mask  = '0;
        up_mask   = '0;
        down_mask = '0;
      end
      default: ;
    endcase
    tgt            = scan_target(car, up);
    st.has_next    = (tgt != NO_TARGET);
    st.next_floor  = (tgt != NO_TARGET) ? NEXT_W'(tgt) : '0;
    st.cab_pending = |cab_mask;
    st.cab_lamps   = CAB_LAMP_W'(32'(cab_mask));
    up_wide        = 32'(up_mask);
    up_wide[FLOORS-1] = 1'b0;
    down_wide      = 32'(down_mask);
    down_wide[0]   = 1'b0;
    st.up_lamps    = up_wide[UP_LAMP_W-1:0];
    st.down_lamps  = down_wide[DOWN_LAMP_W-1:0];
    return st;
  endfunction

  always @(posedge clk) begin
    call_status_t seen;
    call_status_t want;
    if (rst) begin
      cab_mask  = '0;
      up_mask   = '0;
      down_mask = '0;
      status_q.delete();
    end else begin
      if (done) begin
        seen = '{next_floor, has_next, cab_pending, cab_lamps, up_lamps, down_lamps};
        if (status_q.size() == 0) begin
          if (fails < 10)
            $display("unexpected result: next=%0d has=%0b cab=%0b lamps c=%h u=%h d=%h",
                     seen.next_floor, seen.has_next, seen.cab_pending,
                     seen.cab_lamps, seen.up_lamps, seen.down_lamps);
          fails++;
        end else begin
          want = status_q.pop_front();
          if (seen.next_floor !== want.next_floor || seen.has_next !== want.has_next ||
              seen.cab_pending !== want.cab_pending || seen.cab_lamps !== want.cab_lamps ||
              seen.up_lamps !== want.up_lamps || seen.down_lamps !== want.down_lamps) begin
            if (fails < 10)
              $display({"mismatch: expected next=%0d has=%0b cab=%0b lamps c=%h u=%h d=%h,",
                        " got next=%0d has=%0b cab=%0b lamps c=%h u=%h d=%h"},
                       want.next_floor, want.has_next, want.cab_pending,
                       want.cab_lamps, want.up_lamps, want.down_lamps,
                       seen.next_floor, seen.has_next, seen.cab_pending,
                       seen.cab_lamps, seen.up_lamps, seen.down_lamps);
            fails++;
          end
        end
      end
      if (start && !busy)
        status_q.push_back(serve_call(cmd_t'(command), floor, going_up, cab_call));
    end
    mismatch_count <= fails;
    all_checked    <= (status_q.size() == 0);
  end

endmodule

[dv/elevator_call_scheduler_tb.sv]
// ----------------------------------------------------------------------------
// elevator_call_scheduler_tb
// Drives call, clear, clear-all and query transactions into the scheduler:
// a directed run over end floors, every scan pass and lamp masking, then
// about a thousand random transactions with random gaps and bursts. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module elevator_call_scheduler_tb;
  import ecs_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL       = 2 * FLOORS_DEF + 4;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [CMD_W-1:0]       command;
  logic [FLOOR_W-1:0]     floor;
  logic                   going_up;
  logic                   cab_call;
  logic                   done;
  logic [NEXT_W-1:0]      next_floor;
  logic                   has_next;
  logic                   cab_pending;
  logic [CAB_LAMP_W-1:0]  cab_lamps;
  logic [UP_LAMP_W-1:0]   up_lamps;
  logic [DOWN_LAMP_W-1:0] down_lamps;
  int                     mismatch_count;
  logic                   all_checked;
  int                     stall_cycles;
  int                     burst_left;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  elevator_call_scheduler dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .floor(floor), .going_up(going_up), .cab_call(cab_call),
    .done(done), .next_floor(next_floor), .has_next(has_next),
    .cab_pending(cab_pending), .cab_lamps(cab_lamps), .up_lamps(up_lamps),
    .down_lamps(down_lamps)
  );

  elevator_call_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .floor(floor), .going_up(going_up), .cab_call(cab_call),
    .done(done), .next_floor(next_floor), .has_next(has_next),
    .cab_pending(cab_pending), .cab_lamps(cab_lamps), .up_lamps(up_lamps),
    .down_lamps(down_lamps), .mismatch_count(mismatch_count),
    .all_checked(all_checked)
  );

  // idle watchdog: no transaction and no result for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_call(cmd_t cmd, logic [FLOOR_W-1:0] fl, logic up, logic cab);
    int gap;
    int pick;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 3) burst_left = $urandom_range(10, 40);
      if (pick >= 92) gap = $urandom_range(8, 40);
      else if (pick >= 45) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    command  <= cmd;
    floor    <= fl;
    going_up <= up;
    cab_call <= cab;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    int   pick;
    cmd_t cmd;
    rst          = 1'b1;
    start        = 1'b0;
    command      = CMD_QUERY;
    floor        = '0;
    going_up     = 1'b0;
    cab_call     = 1'b0;
    burst_left   = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty masks in both directions
    send_call(CMD_QUERY, 2'd0, 1'b1, 1'b0);
    send_call(CMD_QUERY, 2'd3, 1'b0, 1'b1);
    // unlit hall calls at the end floors still steer the scan
    send_call(CMD_ADD, 2'd3, 1'b1, 1'b0);
    send_call(CMD_QUERY, 2'd0, 1'b1, 1'b0);
    send_call(CMD_ADD, 2'd0, 1'b0, 1'b0);
    send_call(CMD_QUERY, 2'd3, 1'b0, 1'b0);
    // serving an end floor drops both directions
    send_call(CMD_CLEAR, 2'd3, 1'b1, 1'b0);
    send_call(CMD_CLEAR, 2'd0, 1'b0, 1'b1);
    send_call(CMD_ADD, 2'd1, 1'b0, 1'b1);
    send_call(CMD_ADD, 2'd2, 1'b1, 1'b1);
    send_call(CMD_ADD, 2'd0, 1'b1, 1'b0);
    send_call(CMD_ADD, 2'd3, 1'b0, 1'b0);
    send_call(CMD_ADD, 2'd1, 1'b1, 1'b0);
    send_call(CMD_ADD, 2'd2, 1'b0, 1'b0);
    send_call(CMD_QUERY, 2'd2, 1'b1, 1'b0);
    send_call(CMD_QUERY, 2'd1, 1'b0, 1'b1);
    send_call(CMD_QUERY, 2'd3, 1'b1, 1'b0);
    send_call(CMD_CLEAR, 2'd1, 1'b1, 1'b0);
    send_call(CMD_CLEAR, 2'd2, 1'b0, 1'b0);
    // third pass going up, second going down
    send_call(CMD_CLEAR_ALL, 2'd3, 1'b1, 1'b1);
    send_call(CMD_ADD, 2'd0, 1'b1, 1'b0);
    send_call(CMD_QUERY, 2'd2, 1'b1, 1'b0);
    send_call(CMD_QUERY, 2'd1, 1'b0, 1'b0);
    // third pass going down starts at the top floor
    send_call(CMD_CLEAR_ALL, 2'd0, 1'b0, 1'b0);
    send_call(CMD_ADD, 2'd3, 1'b0, 1'b0);
    send_call(CMD_QUERY, 2'd1, 1'b0, 1'b0);

    for (int n = 0; n < 1025; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) cmd = CMD_ADD;
      else if (pick < 65) cmd = CMD_CLEAR;
      else if (pick < 68) cmd = CMD_CLEAR_ALL;
      else cmd = CMD_QUERY;
      send_call(cmd, FLOOR_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end
    start <= 1'b0;

    @(posedge clk);
    while (!all_checked) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
rtl/core/ecs_pkg.sv
rtl/core/ecs_floor_cell.sv
rtl/core/ecs_scan_ctrl.sv
rtl/core/elevator_call_scheduler.sv
dv/elevator_call_checker.sv
dv/elevator_call_scheduler_tb.sv
